>>> sv/team_grouped_fifo_assert.svh
// Assertion macros shared by the team queue RTL.
`ifndef TEAM_GROUPED_FIFO_ASSERT_SVH
`define TEAM_GROUPED_FIFO_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define TGF_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define TGF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define TGF_ASSERT_IMPL(name, ante, cons)
`define TGF_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> sv/tgf_pkg.sv
// Types, sizes and codes shared by the team queue modules.
package tgf_pkg;

	// sizes of the stores
	localparam int NUM_TEAMS   = 64;
	localparam int NUM_MEMBERS = 1024;
	localparam int POOL_DEPTH  = 1024;

	// beat field widths
	localparam int REQ_W    = 2;
	localparam int MEMBER_W = 10;
	localparam int TEAMID_W = 6;
	localparam int STATUS_W = 2;

	// internal index and counter widths
	localparam int TEAM_W    = $clog2(NUM_TEAMS);
	localparam int MBR_W     = $clog2(NUM_MEMBERS);
	localparam int NODE_W    = $clog2(POOL_DEPTH);
	localparam int USED_W    = $clog2(POOL_DEPTH + 1);
	localparam int ORDCNT_W  = $clog2(NUM_TEAMS + 1);
	localparam int OSUM_W    = ORDCNT_W + 1;
	localparam int CLR_DEPTH = (NUM_MEMBERS > POOL_DEPTH) ? NUM_MEMBERS : POOL_DEPTH;
	localparam int CLR_W     = $clog2(CLR_DEPTH);

	typedef enum logic [REQ_W-1:0] {
		REQ_ASSIGN  = 2'd0,
		REQ_ENQUEUE = 2'd1,
		REQ_DEQUEUE = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_DEQ   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ENQ2,
		S_ENQ3,
		S_DEQ2,
		S_DEQ3,
		S_DEQ4,
		S_RESULT
	} state_t;

	// finished result handed to the output register
	typedef struct packed {
		logic                valid;
		status_t             status;
		logic [MEMBER_W-1:0] member;
	} res_t;

	// memory port requests, one type per address/data shape
	typedef struct packed {
		logic              we;
		logic [MBR_W-1:0]  waddr;
		logic [TEAM_W-1:0] wdata;
		logic [MBR_W-1:0]  raddr;
	} mt_req_t;

	typedef struct packed {
		logic              we;
		logic [TEAM_W-1:0] waddr;
		logic [TEAM_W-1:0] wdata;
		logic [TEAM_W-1:0] raddr;
	} to_req_t;

	typedef struct packed {
		logic              we;
		logic [TEAM_W-1:0] waddr;
		logic [NODE_W-1:0] wdata;
		logic [TEAM_W-1:0] raddr;
	} tn_req_t;

	// per-team busy flag
	typedef struct packed {
		logic              we;
		logic [TEAM_W-1:0] waddr;
		logic              wdata;
		logic [TEAM_W-1:0] raddr;
	} ne_req_t;

	typedef struct packed {
		logic                we;
		logic [NODE_W-1:0]   waddr;
		logic [MEMBER_W-1:0] wdata;
		logic [NODE_W-1:0]   raddr;
	} nm_req_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		logic [NODE_W-1:0] wdata;
		logic [NODE_W-1:0] raddr;
	} nn_req_t;

endpackage

>>> sv/tgf_ram.sv
// Generic single-write, single-read synchronous RAM, read-first, with registered read data.
module tgf_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// a read of the entry written in the same cycle returns the old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/tgf_ctrl.sv
// Sequencer for the team queue: walks the linked lists held in the RAMs.
module tgf_ctrl import tgf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [MEMBER_W-1:0] member_id,
	input  logic [TEAMID_W-1:0] team_id,
	input  logic                out_free,
	output res_t                res,
	output mt_req_t             mt_req,
	input  logic [TEAM_W-1:0]   mt_rdata,
	output to_req_t             ord_req,
	input  logic [TEAM_W-1:0]   ord_rdata,
	output tn_req_t             first_req,
	input  logic [NODE_W-1:0]   first_rdata,
	output tn_req_t             last_req,
	input  logic [NODE_W-1:0]   last_rdata,
	output ne_req_t             busy_req,
	input  logic                busy_rdata,
	output nm_req_t             nmem_req,
	input  logic [MEMBER_W-1:0] nmem_rdata,
	output nn_req_t             link_req,
	input  logic [NODE_W-1:0]   link_rdata,
	output nn_req_t             free_req,
	input  logic [NODE_W-1:0]   free_rdata
);

	// control state
	state_t                state_q, state_d;
	logic [CLR_W-1:0]      clr_q, clr_d;
	logic [USED_W-1:0]     used_q, used_d;
	logic [TEAM_W-1:0]     head_q, head_d;
	logic [ORDCNT_W-1:0]   cnt_q, cnt_d;

	// per-item payload
	logic [MEMBER_W-1:0]   member_q, member_d;
	logic                  mbr_ok_q, mbr_ok_d;
	logic [NODE_W-1:0]     node_q, node_d;
	logic [TEAM_W-1:0]     team_q, team_d;
	logic                  tail_q, tail_d;
	status_t               hold_status_q;
	logic [MEMBER_W-1:0]   hold_member_q;

	logic                  fin;
	status_t               fin_status;
	logic [MEMBER_W-1:0]   fin_member;
	logic                  mbr_in, team_in;
	logic [TEAM_W-1:0]     enq_team;
	logic [TEAM_W-1:0]     head_next;
	logic [OSUM_W-1:0]     tail_sum;
	logic [TEAM_W-1:0]     tail_idx;

	assign mbr_in = 32'(member_id) < NUM_MEMBERS;
	assign team_in = 32'(team_id) < NUM_TEAMS;
	assign enq_team = mbr_ok_q ? mt_rdata : '0;
	assign head_next = (head_q == TEAM_W'(NUM_TEAMS - 1)) ? '0 : head_q + 1'b1;

	// back of the team order, wrapped with one compare-subtract
	always_comb begin
		tail_sum = OSUM_W'(head_q) + OSUM_W'(cnt_q);
		if (tail_sum >= OSUM_W'(NUM_TEAMS)) begin
			tail_sum = tail_sum - OSUM_W'(NUM_TEAMS);
		end
		tail_idx = TEAM_W'(tail_sum);
	end

	// next state, memory requests and result
	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		used_d = used_q;
		head_d = head_q;
		cnt_d = cnt_q;
		member_d = member_q;
		mbr_ok_d = mbr_ok_q;
		node_d = node_q;
		team_d = team_q;
		tail_d = tail_q;
		mt_req = '0;
		ord_req = '0;
		first_req = '0;
		last_req = '0;
		busy_req = '0;
		nmem_req = '0;
		link_req = '0;
		free_req = '0;
		fin = 1'b0;
		fin_status = ST_OK;
		fin_member = '0;
		in_stall = 1'b1;
		res = '0;

		case (state_q)
			// clearing pass: team map to zero, busy flags off, free stack to identity
			S_CLEAR: begin
				if (32'(clr_q) < NUM_MEMBERS) begin
					mt_req.we = 1'b1;
					mt_req.waddr = MBR_W'(clr_q);
				end
				if (32'(clr_q) < NUM_TEAMS) begin
					busy_req.we = 1'b1;
					busy_req.waddr = TEAM_W'(clr_q);
				end
				if (32'(clr_q) < POOL_DEPTH) begin
					free_req.we = 1'b1;
					free_req.waddr = NODE_W'(clr_q);
					free_req.wdata = NODE_W'(clr_q);
				end
				if (32'(clr_q) == CLR_DEPTH - 1) begin
					state_d = S_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (req_t'(req_type))
						REQ_ASSIGN: begin
							if (mbr_in && team_in) begin
								mt_req.we = 1'b1;
								mt_req.waddr = MBR_W'(member_id);
								mt_req.wdata = TEAM_W'(team_id);
							end
							fin = 1'b1;
						end
						REQ_ENQUEUE: begin
							if (32'(used_q) >= POOL_DEPTH) begin
								fin = 1'b1;
								fin_status = ST_FULL;
							end else begin
								mt_req.raddr = MBR_W'(member_id);
								free_req.raddr = NODE_W'(used_q);
								used_d = used_q + 1'b1;
								member_d = member_id;
								mbr_ok_d = mbr_in;
								state_d = S_ENQ2;
							end
						end
						REQ_DEQUEUE: begin
							if (cnt_q == '0) begin
								fin = 1'b1;
								fin_status = ST_EMPTY;
							end else begin
								ord_req.raddr = head_q;
								state_d = S_DEQ2;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			// team and free node known: place the node, fetch the old tail and busy flag
			S_ENQ2: begin
				node_d = free_rdata;
				team_d = enq_team;
				busy_req.raddr = enq_team;
				busy_req.we = 1'b1;
				busy_req.waddr = enq_team;
				busy_req.wdata = 1'b1;
				last_req.raddr = enq_team;
				last_req.we = 1'b1;
				last_req.waddr = enq_team;
				last_req.wdata = free_rdata;
				nmem_req.we = 1'b1;
				nmem_req.waddr = free_rdata;
				nmem_req.wdata = member_q;
				link_req.we = 1'b1;
				link_req.waddr = free_rdata;
				link_req.wdata = free_rdata;
				state_d = S_ENQ3;
			end
			// chain behind the old tail, or open the list and queue the team
			S_ENQ3: begin
				if (busy_rdata) begin
					link_req.we = 1'b1;
					link_req.waddr = last_rdata;
					link_req.wdata = node_q;
				end else begin
					first_req.we = 1'b1;
					first_req.waddr = team_q;
					first_req.wdata = node_q;
					if (32'(cnt_q) < NUM_TEAMS) begin
						ord_req.we = 1'b1;
						ord_req.waddr = tail_idx;
						ord_req.wdata = team_q;
						cnt_d = cnt_q + 1'b1;
					end
				end
				fin = 1'b1;
			end
			// front team known: fetch its head and tail
			S_DEQ2: begin
				team_d = ord_rdata;
				first_req.raddr = ord_rdata;
				last_req.raddr = ord_rdata;
				state_d = S_DEQ3;
			end
			// head node known: fetch it, retire the team if it was the last node
			S_DEQ3: begin
				nmem_req.raddr = first_rdata;
				link_req.raddr = first_rdata;
				tail_d = (first_rdata == last_rdata);
				if (first_rdata == last_rdata) begin
					busy_req.we = 1'b1;
					busy_req.waddr = team_q;
					busy_req.wdata = 1'b0;
					head_d = head_next;
					cnt_d = cnt_q - 1'b1;
				end
				if (used_q != '0) begin
					used_d = used_q - 1'b1;
					free_req.we = 1'b1;
					free_req.waddr = NODE_W'(used_q - 1'b1);
					free_req.wdata = first_rdata;
				end
				state_d = S_DEQ4;
			end
			// advance the team head and report the member
			S_DEQ4: begin
				if (!tail_q) begin
					first_req.we = 1'b1;
					first_req.waddr = team_q;
					first_req.wdata = link_rdata;
				end
				fin = 1'b1;
				fin_status = ST_DEQ;
				fin_member = nmem_rdata;
			end
			// result held until the output register frees up
			S_RESULT: begin
				if (out_free) begin
					res.valid = 1'b1;
					res.status = hold_status_q;
					res.member = hold_member_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// finishing beat: straight out if the slot is free, else hold it
		if (fin) begin
			if (out_free) begin
				res.valid = 1'b1;
				res.status = fin_status;
				res.member = fin_member;
				state_d = S_IDLE;
			end else begin
				state_d = S_RESULT;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			used_q <= '0;
			head_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			used_q <= used_d;
			head_q <= head_d;
			cnt_q <= cnt_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		member_q <= member_d;
		mbr_ok_q <= mbr_ok_d;
		node_q <= node_d;
		team_q <= team_d;
		tail_q <= tail_d;
		if (fin) begin
			hold_status_q <= fin_status;
			hold_member_q <= fin_member;
		end
	end

endmodule

>>> sv/team_grouped_fifo.sv
// Team queue top level: sequencer, list RAMs and output register.
// Team queue. An assign beat maps a member to a team; an enqueue beat puts the
// member behind the last waiting member of its team, and a team that was empty
// joins the back of the team order; a dequeue beat returns the front member of
// the front team. Every input beat gives exactly one result beat. After reset
// the block runs a clearing pass over 1024 entries (the larger of the member
// count and the node pool depth), with in_stall high, that zeroes the team map,
// clears the per-team busy flags and refills the free-node stack. Afterwards
// an assign, an enqueue into a full pool, a dequeue of an empty queue or an
// unknown request finishes in the idle state; an enqueue steps on through
// S_ENQ2 and S_ENQ3, a dequeue through S_DEQ2, S_DEQ3 and S_DEQ4, along the
// chain of dependent registered RAM reads (team map and free stack, then team
// tail and busy flag; team order, team head and tail, node member and link).
// The next beat is taken while a finished result waits in the output register;
// if the output register is still occupied when an item finishes, the block
// holds that result and takes no new beat until it moves out.
`include "team_grouped_fifo_assert.svh"

module team_grouped_fifo import tgf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [MEMBER_W-1:0] member_id,
	input  logic [TEAMID_W-1:0] team_id,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [MEMBER_W-1:0] out_member
);

	res_t                res;
	logic                out_free;
	mt_req_t             mt_req;
	to_req_t             ord_req;
	tn_req_t             first_req, last_req;
	ne_req_t             busy_req;
	nm_req_t             nmem_req;
	nn_req_t             link_req, free_req;
	logic [TEAM_W-1:0]   mt_rdata, ord_rdata;
	logic [NODE_W-1:0]   first_rdata, last_rdata, link_rdata, free_rdata;
	logic                busy_rdata;
	logic [MEMBER_W-1:0] nmem_rdata;

	logic                out_valid_q;
	status_t             status_q;
	logic [MEMBER_W-1:0] out_member_q;

	tgf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.member_id   (member_id),
		.team_id     (team_id),
		.out_free    (out_free),
		.res         (res),
		.mt_req      (mt_req),
		.mt_rdata    (mt_rdata),
		.ord_req     (ord_req),
		.ord_rdata   (ord_rdata),
		.first_req   (first_req),
		.first_rdata (first_rdata),
		.last_req    (last_req),
		.last_rdata  (last_rdata),
		.busy_req    (busy_req),
		.busy_rdata  (busy_rdata),
		.nmem_req    (nmem_req),
		.nmem_rdata  (nmem_rdata),
		.link_req    (link_req),
		.link_rdata  (link_rdata),
		.free_req    (free_req),
		.free_rdata  (free_rdata)
	);

	// member to team map
	tgf_ram #(.DEPTH(NUM_MEMBERS), .WIDTH(TEAM_W)) u_member_team (
		.clk(clk), .we(mt_req.we), .waddr(mt_req.waddr), .wdata(mt_req.wdata),
		.raddr(mt_req.raddr), .rdata(mt_rdata)
	);

	// circular order of non-empty teams
	tgf_ram #(.DEPTH(NUM_TEAMS), .WIDTH(TEAM_W)) u_team_order (
		.clk(clk), .we(ord_req.we), .waddr(ord_req.waddr), .wdata(ord_req.wdata),
		.raddr(ord_req.raddr), .rdata(ord_rdata)
	);

	// head and tail node of each team list
	tgf_ram #(.DEPTH(NUM_TEAMS), .WIDTH(NODE_W)) u_team_first (
		.clk(clk), .we(first_req.we), .waddr(first_req.waddr), .wdata(first_req.wdata),
		.raddr(first_req.raddr), .rdata(first_rdata)
	);

	tgf_ram #(.DEPTH(NUM_TEAMS), .WIDTH(NODE_W)) u_team_last (
		.clk(clk), .we(last_req.we), .waddr(last_req.waddr), .wdata(last_req.wdata),
		.raddr(last_req.raddr), .rdata(last_rdata)
	);

	// busy flag of each team: set while it has waiting members
	tgf_ram #(.DEPTH(NUM_TEAMS), .WIDTH(1)) u_team_busy (
		.clk(clk), .we(busy_req.we), .waddr(busy_req.waddr), .wdata(busy_req.wdata),
		.raddr(busy_req.raddr), .rdata(busy_rdata)
	);

	// node pool: member and next link
	tgf_ram #(.DEPTH(POOL_DEPTH), .WIDTH(MEMBER_W)) u_node_member (
		.clk(clk), .we(nmem_req.we), .waddr(nmem_req.waddr), .wdata(nmem_req.wdata),
		.raddr(nmem_req.raddr), .rdata(nmem_rdata)
	);

	tgf_ram #(.DEPTH(POOL_DEPTH), .WIDTH(NODE_W)) u_node_link (
		.clk(clk), .we(link_req.we), .waddr(link_req.waddr), .wdata(link_req.wdata),
		.raddr(link_req.raddr), .rdata(link_rdata)
	);

	// stack of free node indices
	tgf_ram #(.DEPTH(POOL_DEPTH), .WIDTH(NODE_W)) u_free_nodes (
		.clk(clk), .we(free_req.we), .waddr(free_req.waddr), .wdata(free_req.wdata),
		.raddr(free_req.raddr), .rdata(free_rdata)
	);

	// output register: free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q <= res.status;
			out_member_q <= res.member;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_member = out_member_q;

	// a result never lands on a held beat, is never lost, and only a dequeue names a member
	`TGF_ASSERT_IMPL(a_res_slot_free, res.valid, out_free)
	`TGF_ASSERT_NEXT(a_res_lands, res.valid, out_valid_q)
	`TGF_ASSERT_IMPL(a_member_only_deq, out_valid_q && (status_q != ST_DEQ), out_member_q == '0)

endmodule

>>> tb/sv/team_queue_checker.sv
// Team queue checker: predicts each result beat and compares it with the block's output.
module team_queue_checker import tgf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [MEMBER_W-1:0] member_id,
	input  logic [TEAMID_W-1:0] team_id,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic [MEMBER_W-1:0] out_member,
	output int                  mismatches,
	output int                  awaiting
);

	typedef struct packed {
		status_t             status;
		logic [MEMBER_W-1:0] member;
	} result_t;

	// predicted queue state
	logic [TEAM_W-1:0]   team_of_member [NUM_MEMBERS];
	logic [TEAM_W-1:0]   team_fifo      [NUM_TEAMS];
	logic [TEAM_W-1:0]   team_fifo_head;
	logic [ORDCNT_W-1:0] team_fifo_count;
	logic                team_busy      [NUM_TEAMS];
	logic [NODE_W-1:0]   head_node      [NUM_TEAMS];
	logic [NODE_W-1:0]   tail_node      [NUM_TEAMS];
	logic [MEMBER_W-1:0] node_owner     [POOL_DEPTH];
	logic [NODE_W-1:0]   next_node      [POOL_DEPTH];
	logic [NODE_W-1:0]   free_stack     [POOL_DEPTH];
	logic [USED_W-1:0]   nodes_in_use;

	result_t awaited_results[$];
	int      fail_count;

	task automatic clear_queue_state();
		for (int i = 0; i < NUM_MEMBERS; i++)
			team_of_member[i] = '0;
		for (int i = 0; i < NUM_TEAMS; i++) begin
			team_fifo[i] = '0;
			team_busy[i] = 1'b0;
			head_node[i] = '0;
			tail_node[i] = '0;
		end
		for (int i = 0; i < POOL_DEPTH; i++) begin
			node_owner[i] = '0;
			next_node[i]  = '0;
			free_stack[i] = NODE_W'(i);
		end
		team_fifo_head  = '0;
		team_fifo_count = '0;
		nodes_in_use    = '0;
	endtask

	// one request beat in, the result it causes out
	task automatic team_queue_step(input logic [REQ_W-1:0] rq, input logic [MEMBER_W-1:0] mbr,
			input logic [TEAMID_W-1:0] tid, output result_t res);
		logic [TEAM_W-1:0] team;
		logic [TEAM_W-1:0] slot;
		logic [NODE_W-1:0] node;
		res.status = ST_OK;
		res.member = '0;
		case (rq)
			REQ_ASSIGN: begin
				team_of_member[mbr] = tid;
			end
			REQ_ENQUEUE: begin
				team = team_of_member[mbr];
				if (nodes_in_use >= USED_W'(POOL_DEPTH)) begin
					res.status = ST_FULL;
				end else begin
					node = free_stack[nodes_in_use];
					nodes_in_use++;
					node_owner[node] = mbr;
					next_node[node]  = node;
					if (team_busy[team]) begin
						// append behind the team's tail
						next_node[tail_node[team]] = node;
						tail_node[team]            = node;
					end else begin
						// team becomes non-empty and joins the back of the order
						team_busy[team] = 1'b1;
						head_node[team] = node;
						tail_node[team] = node;
						if (team_fifo_count < ORDCNT_W'(NUM_TEAMS)) begin
							slot = team_fifo_head + TEAM_W'(team_fifo_count);
							team_fifo[slot] = team;
							team_fifo_count++;
						end
					end
				end
			end
			REQ_DEQUEUE: begin
				if (team_fifo_count == '0) begin
					res.status = ST_EMPTY;
				end else begin
					team = team_fifo[team_fifo_head];
					node = head_node[team];
					res.status = ST_DEQ;
					res.member = node_owner[node];
					if (node == tail_node[team]) begin
						// last member gone: team leaves the order
						team_busy[team] = 1'b0;
						team_fifo_head++;
						team_fifo_count--;
					end else begin
						head_node[team] = next_node[node];
					end
					if (nodes_in_use != '0) begin
						nodes_in_use--;
						free_stack[nodes_in_use] = node;
					end
				end
			end
			default: ; // unused request code: no effect, status ok
		endcase
	endtask

	// input beats feed the predictor, output beats are checked in order
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_queue_state();
			awaited_results.delete();
			fail_count = 0;
			mismatches <= 0;
			awaiting   <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				team_queue_step(req_type, member_id, team_id, want);
				awaited_results.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got status %0d member %0d",
						$time, status, out_member);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, want.status, status);
						fail_count++;
					end
					if (out_member !== want.member) begin
						$display("%0t: out_member expected %0d got %0d",
							$time, want.member, out_member);
						fail_count++;
					end
				end
			end
			mismatches <= fail_count;
			awaiting   <= awaited_results.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Team queue testbench top: clock, reset, request stimulus, result stall and verdict.
module testbench;
	import tgf_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BEATS = 1750;
	localparam int DRAIN_CYCLES = 16;
	// request code that the block must ignore
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [REQ_W-1:0]    req_type;
	logic [MEMBER_W-1:0] member_id;
	logic [TEAMID_W-1:0] team_id;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [MEMBER_W-1:0] out_member;

	int          mismatches;
	int          awaiting;
	int unsigned cycles = 0;
	int          burst_left = 0;
	int          occupancy = 0;
	int          beats_sent = 0;
	int          stall_mode = 0;
	int          stall_left = 0;

	always #5 clk = ~clk;

	team_grouped_fifo dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.member_id  (member_id),
		.team_id    (team_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_member (out_member)
	);

	team_queue_checker order_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.member_id  (member_id),
		.team_id    (team_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_member (out_member),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result stall: switches between patterns: none, 30% or 75% random, or periodic
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 99) < 30);
			2:       out_stall <= ($urandom_range(0, 99) < 75);
			default: out_stall <= cycles[2] & cycles[0];
		endcase
	end

	// present one request beat, hold it until taken, then maybe pause
	task automatic send_request(input logic [REQ_W-1:0] rq, input logic [MEMBER_W-1:0] mbr,
			input logic [TEAMID_W-1:0] tid);
		int gap;
		in_valid  <= 1'b1;
		req_type  <= rq;
		member_id <= mbr;
		team_id   <= tid;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		if (rq == REQ_ENQUEUE && occupancy < POOL_DEPTH)
			occupancy++;
		else if (rq == REQ_DEQUEUE && occupancy > 0)
			occupancy--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// members and teams: half from a small set, half anywhere
	function automatic logic [MEMBER_W-1:0] pick_member();
		if ($urandom_range(0, 1) == 0)
			return MEMBER_W'($urandom_range(0, 31));
		return MEMBER_W'($urandom_range(0, NUM_MEMBERS - 1));
	endfunction

	function automatic logic [TEAMID_W-1:0] pick_team();
		if ($urandom_range(0, 1) == 0)
			return TEAMID_W'($urandom_range(0, 3));
		return TEAMID_W'($urandom_range(0, NUM_TEAMS - 1));
	endfunction

	// weighted random request: percentages for assign, enqueue, dequeue; rest unused code
	task automatic send_random(input int assign_pct, input int enq_pct, input int deq_pct);
		int roll;
		logic [REQ_W-1:0] rq;
		roll = $urandom_range(0, 99);
		if (roll < assign_pct)
			rq = REQ_ASSIGN;
		else if (roll < assign_pct + enq_pct)
			rq = REQ_ENQUEUE;
		else if (roll < assign_pct + enq_pct + deq_pct)
			rq = REQ_DEQUEUE;
		else
			rq = REQ_UNUSED;
		send_request(rq, pick_member(), pick_team());
	endtask

	initial begin
		int first_random;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		req_type  <= REQ_ASSIGN;
		member_id <= '0;
		team_id   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty dequeue, team extremes, grouping, reassign, unused code
		send_request(REQ_DEQUEUE, '0, '0);
		send_request(REQ_ASSIGN, 10'd1023, 6'd63);
		send_request(REQ_ASSIGN, 10'd5, 6'd1);
		send_request(REQ_ASSIGN, 10'd682, 6'd42);
		send_request(REQ_ENQUEUE, 10'd1023, '0);
		send_request(REQ_ENQUEUE, 10'd0, '0);
		send_request(REQ_ENQUEUE, 10'd5, '0);
		send_request(REQ_ENQUEUE, 10'd1022, '0);
		send_request(REQ_ENQUEUE, 10'd1023, '0);
		send_request(REQ_UNUSED, 10'd1023, 6'd63);
		send_request(REQ_ASSIGN, 10'd1023, 6'd0);
		send_request(REQ_ENQUEUE, 10'd1023, '0);
		send_request(REQ_ENQUEUE, 10'd682, '0);
		repeat (7)
			send_request(REQ_DEQUEUE, '0, '0);
		send_request(REQ_DEQUEUE, 10'd1023, 6'd63);
		send_request(REQ_UNUSED, '0, '0);

		// random: mixed traffic first
		first_random = beats_sent;
		while (beats_sent - first_random < 350)
			send_random(25, 40, 30);
		// fill the node pool, then keep pushing to hit the full drop
		while (occupancy < POOL_DEPTH)
			send_random(3, 92, 4);
		repeat (40)
			send_random(5, 80, 10);
		// drain-heavy remainder
		while (beats_sent - first_random < RANDOM_BEATS)
			send_random(8, 30, 60);
		in_valid <= 1'b0;

		// let every result come back, then a short quiet tail
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/tgf_pkg.sv
sv/tgf_ram.sv
sv/tgf_ctrl.sv
sv/team_grouped_fifo.sv
tb/sv/team_queue_checker.sv
tb/sv/testbench.sv
